// ===== rtl/sc2a_pkg.sv =====
package sc2a_pkg;

	localparam int unsigned CodeW  = 8;
	localparam int unsigned AsciiW = 7;
	localparam int unsigned MapIdxW = 6;
	localparam int unsigned MapDepth = 58;

	localparam logic [CodeW-1:0]  CODE_LSHIFT_MAKE  = 8'h2a;
	localparam logic [CodeW-1:0]  CODE_LSHIFT_BREAK = 8'haa;
	localparam logic [CodeW-1:0]  CODE_RSHIFT_MAKE  = 8'h36;
	localparam logic [CodeW-1:0]  CODE_RSHIFT_BREAK = 8'hb6;
	localparam logic [CodeW-1:0]  CODE_LCTRL_MAKE   = 8'h1d;
	localparam logic [CodeW-1:0]  CODE_LCTRL_BREAK  = 8'h9d;
	localparam logic [CodeW-1:0]  CODE_EXT_PREFIX   = 8'he0;
	localparam logic [AsciiW-1:0] LAST_MAPPED_CODE  = 7'h39;

	// indexed by the low seven bits of a make or break code
	localparam logic [AsciiW-1:0] PLAIN_MAP [MapDepth] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
		7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
		7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00, 7'h00, 7'h20
	};

	localparam logic [AsciiW-1:0] UPPER_MAP [MapDepth] = '{
		7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
		7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
		7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
		7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00, 7'h00, 7'h20
	};

	typedef struct packed {
		logic [CodeW-1:0] scan_byte;
	} in_beat_t;

	typedef struct packed {
		logic [CodeW-1:0]  scan_echo;
		logic [AsciiW-1:0] ascii_key;
		logic [AsciiW-1:0] pressed_key;
		logic              is_press;
		logic              shift_active;
		logic              ctrl_active;
		logic              escape_prefix;
	} out_beat_t;

	typedef struct packed {
		logic shift;
		logic ctrl;
	} mod_flags_t;

endpackage

// ===== rtl/sc2a_stream_if.sv =====
interface sc2a_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sc2a_mod_track.sv =====
module sc2a_mod_track (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [sc2a_pkg::CodeW-1:0] scan_byte,
	output sc2a_pkg::mod_flags_t       flags_next
);
	logic lshift_q, rshift_q, lctrl_q;
	logic lshift_d, rshift_d, lctrl_d;

	always_comb begin
		lshift_d = lshift_q;
		rshift_d = rshift_q;
		lctrl_d  = lctrl_q;
		unique case (scan_byte)
			sc2a_pkg::CODE_LSHIFT_MAKE:  lshift_d = 1'b1;
			sc2a_pkg::CODE_LSHIFT_BREAK: lshift_d = 1'b0;
			sc2a_pkg::CODE_RSHIFT_MAKE:  rshift_d = 1'b1;
			sc2a_pkg::CODE_RSHIFT_BREAK: rshift_d = 1'b0;
			sc2a_pkg::CODE_LCTRL_MAKE:   lctrl_d  = 1'b1;
			sc2a_pkg::CODE_LCTRL_BREAK:  lctrl_d  = 1'b0;
			default: ;
		endcase
	end

	// commit only when the byte moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			lctrl_q  <= 1'b0;
		end else if (advance) begin
			lshift_q <= lshift_d;
			rshift_q <= rshift_d;
			lctrl_q  <= lctrl_d;
		end
	end

	assign flags_next.shift = lshift_d | rshift_d;
	assign flags_next.ctrl  = lctrl_d;
endmodule

// ===== rtl/sc2a_xlate.sv =====
module sc2a_xlate (
	input  logic [sc2a_pkg::CodeW-1:0]  scan_byte,
	input  sc2a_pkg::mod_flags_t        flags,
	output sc2a_pkg::out_beat_t         result
);
	logic [sc2a_pkg::AsciiW-1:0]  low_code;
	logic [sc2a_pkg::MapIdxW-1:0] map_idx;
	logic [sc2a_pkg::AsciiW-1:0]  key;
	logic                         press;

	assign low_code = scan_byte[sc2a_pkg::AsciiW-1:0];
	assign map_idx  = low_code[sc2a_pkg::MapIdxW-1:0];
	assign press    = ~scan_byte[sc2a_pkg::CodeW-1];

	always_comb begin
		if (low_code > sc2a_pkg::LAST_MAPPED_CODE) begin
			key = '0;
		end else if (flags.shift) begin
			key = sc2a_pkg::UPPER_MAP[map_idx];
		end else begin
			key = sc2a_pkg::PLAIN_MAP[map_idx];
		end
	end

	assign result.scan_echo     = scan_byte;
	assign result.ascii_key     = key;
	assign result.pressed_key   = press ? key : '0;
	assign result.is_press      = press;
	assign result.shift_active  = flags.shift;
	assign result.ctrl_active   = flags.ctrl;
	assign result.escape_prefix = (scan_byte == sc2a_pkg::CODE_EXT_PREFIX);
endmodule

// ===== rtl/scan_code_to_ascii_translator.sv =====
// Translates set-1 keyboard scan bytes to ASCII, one result beat per scan beat. A byte
// is taken every cycle when the result side keeps up; each byte passes through the input
// register and then the result register, with the left/right shift and left
// ctrl flags updated as each byte passes from the first to the second. Bit 7 marks a
// release: the byte is still translated (ascii_key) but pressed_key reads zero. Bytes
// whose low seven bits exceed 0x39 and keys with no character give zero. An 0xE0 prefix
// raises escape_prefix only. A stalled result holds while the input register still takes
// one more byte.
module scan_code_to_ascii_translator (
	input  logic         clk,
	input  logic         arst_n,
	sc2a_stream_if.sink   scan_in,
	sc2a_stream_if.source key_out
);
	logic                       valid_s1;
	logic [sc2a_pkg::CodeW-1:0] scan_s1;
	logic                       valid_s2;
	sc2a_pkg::out_beat_t        result_s2;
	logic                       load_s2;
	logic                       load_s1;
	sc2a_pkg::mod_flags_t       flags_next;
	sc2a_pkg::out_beat_t        result_d;

	assign load_s2 = valid_s1 & (~valid_s2 | key_out.ready);
	assign load_s1 = scan_in.valid & scan_in.ready;
	assign scan_in.ready = ~valid_s1 | load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_in.ready) begin
			valid_s1 <= scan_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			scan_s1 <= scan_in.data.scan_byte;
		end
	end

	sc2a_mod_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (load_s2),
		.scan_byte  (scan_s1),
		.flags_next (flags_next)
	);

	sc2a_xlate u_xlate (
		.scan_byte (scan_s1),
		.flags     (flags_next),
		.result    (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | key_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result_d;
		end
	end

	assign key_out.valid = valid_s2;
	assign key_out.data  = result_s2;
endmodule

// ===== rtl/sc2a_checker.sv =====
module sc2a_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input sc2a_pkg::out_beat_t out_data
);
	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_press |-> out_data.pressed_key == '0)
		else $error("release beat carries a pressed key");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_press |-> out_data.pressed_key == out_data.ascii_key)
		else $error("press beat lost its key");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.escape_prefix |->
			out_data.scan_echo == sc2a_pkg::CODE_EXT_PREFIX && out_data.ascii_key == '0)
		else $error("escape prefix on wrong byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.is_press == !out_data.scan_echo[sc2a_pkg::CodeW-1])
		else $error("press flag disagrees with echoed byte");
endmodule

bind scan_code_to_ascii_translator sc2a_checker u_sc2a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (key_out.valid),
	.out_ready (key_out.ready),
	.out_data  (key_out.data)
);
